[rtl/qlu_pkg.sv]
// ----------------------------------------------------------------------------
// Quoted literal unescaper package
// Shared item types, state record, codes and character constants.
// ----------------------------------------------------------------------------
package qlu_pkg;

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_QUOTE    = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY = 1'd1;

	localparam logic [7:0]  QUOTE_RESET    = 8'd34;
	localparam logic [15:0] CAPACITY_RESET = 16'd4096;

	localparam logic [7:0] CH_NUL       = 8'd0;
	localparam logic [7:0] CH_DQUOTE    = 8'd34;
	localparam logic [7:0] CH_SQUOTE    = 8'd39;
	localparam logic [7:0] CH_BACKSLASH = 8'd92;
	localparam logic [7:0] CH_LOWER_X   = 8'd120;
	localparam logic [7:0] CH_LOWER_T   = 8'd116;
	localparam logic [7:0] CH_LOWER_N   = 8'd110;
	localparam logic [7:0] CH_LOWER_V   = 8'd118;
	localparam logic [7:0] CH_LOWER_F   = 8'd102;
	localparam logic [7:0] CH_LOWER_R   = 8'd114;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_LF        = 8'd10;
	localparam logic [7:0] CH_VT        = 8'd11;
	localparam logic [7:0] CH_FF        = 8'd12;
	localparam logic [7:0] CH_CR        = 8'd13;

	localparam logic [7:0] FOLD_ABOVE  = 8'd96;
	localparam logic [7:0] FOLD_OFFSET = 8'd32;
	localparam logic [7:0] DIGIT_BASE  = 8'd48;
	localparam logic [7:0] DIGIT_LAST  = 8'd57;
	localparam logic [7:0] ALPHA_BASE  = 8'd55;
	localparam logic [7:0] ALPHA_FIRST = 8'd65;
	localparam logic [7:0] ALPHA_LAST  = 8'd70;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_UNMATCHED = 3'd1,
		ERR_CUT_ESC   = 3'd2,
		ERR_CUT_HEX   = 3'd3,
		ERR_BAD_HEX   = 3'd4,
		ERR_UNKNOWN   = 3'd5,
		ERR_FULL      = 3'd6
	} err_t;

	typedef enum logic [1:0] {
		PH_PLAIN = 2'd0,
		PH_ESC   = 2'd1,
		PH_HEX1  = 2'd2,
		PH_HEX2  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       at_end;
	} src_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		err_t        error_code;
		logic [15:0] decoded_length;
	} res_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  high_nibble;
		logic [15:0] byte_count;
	} dec_state_t;

	// Folds lower case to upper by the fixed offset.
	function automatic logic [7:0] fold_byte(input logic [7:0] c);
		return (c > FOLD_ABOVE) ? c - FOLD_OFFSET : c;
	endfunction

	// Bit 4 set means the folded byte is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] f);
		logic [7:0] d;
		d = 8'd0;
		if (f >= DIGIT_BASE && f <= DIGIT_LAST) begin
			d = f - DIGIT_BASE;
			return {1'b0, d[3:0]};
		end
		if (f >= ALPHA_FIRST && f <= ALPHA_LAST) begin
			d = f - ALPHA_BASE;
			return {1'b0, d[3:0]};
		end
		return 5'h10;
	endfunction

endpackage

[rtl/quoted_literal_unescaper.sv]
// ----------------------------------------------------------------------------
// Quoted literal unescaper
// Decodes the body of a quoted literal, one source byte per item.
// ----------------------------------------------------------------------------
// Source items (src_valid, src_ready, src_data) carry one raw byte of the
// literal after its opening quote, or an end-of-input mark. Result items
// (res_valid, res_ready, res_data) report each decoded byte, the close of
// the literal with its length, or an error. A backslash, the x of a hex
// escape or its first digit gives no result item.
// An accepted item is held in an input register and is decoded from there
// into the result register once that register is free or being taken. One
// item is taken every cycle while results drain.
// When the receiver stalls, the result register holds its item, the input
// register fills, and src_ready falls until the result is taken.
// The cfg_we port writes the close quote and capacity registers; the user
// must use it only while no item is in flight; the block does not enforce it.
// Reset empties both registers, returns the decoder to plain characters
// with a zero count, and loads a double quote and a capacity of 4096.
// ----------------------------------------------------------------------------
module quoted_literal_unescaper
	import qlu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_ready,
	input  src_item_t              src_data,
	output logic                   res_valid,
	input  logic                   res_ready,
	output res_item_t              res_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic        valid_s1;
	src_item_t   item_s1;
	logic        res_valid_q;
	res_item_t   res_data_q;
	dec_state_t  st_q;
	dec_state_t  st_nxt;
	logic [7:0]  quote_q;
	logic [15:0] cap_q;
	logic        advance;
	logic        has_result;
	res_item_t   result;

	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign src_ready = !valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	qlu_decode u_decode (
		.cur        (st_q),
		.item       (item_s1),
		.quote_char (quote_q),
		.capacity   (cap_q),
		.nxt        (st_nxt),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			st_q        <= '{phase: PH_PLAIN, high_nibble: 4'd0, byte_count: 16'd0};
			quote_q     <= QUOTE_RESET;
			cap_q       <= CAPACITY_RESET;
		end else begin
			if (src_ready) begin
				valid_s1 <= src_valid;
			end
			if (advance) begin
				st_q        <= st_nxt;
				res_valid_q <= has_result;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_QUOTE: quote_q <= cfg_wdata[7:0];
					REG_CAPACITY: cap_q <= cfg_wdata;
					default: cap_q <= cap_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			item_s1 <= src_data;
		end
		if (advance) begin
			res_data_q <= result;
		end
	end

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_close_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_CLOSE |->
		res_data.error_code == ERR_NONE && res_data.out_byte == 8'd0)
		else $error("close item carries an error code or byte");

	a_error_coded: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_ERROR |-> res_data.error_code != ERR_NONE)
		else $error("error item without an error code");

	a_byte_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind == KIND_BYTE |->
		res_data.error_code == ERR_NONE && res_data.decoded_length != 16'd0)
		else $error("decoded byte item with bad code or zero length");

	a_full_at_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.error_code == ERR_FULL |-> res_data.decoded_length >= cap_q)
		else $error("full error below capacity");

endmodule

[rtl/qlu_decode.sv]
// ----------------------------------------------------------------------------
// Quoted literal unescaper decode step
// Next state and optional result for one source byte.
// ----------------------------------------------------------------------------
module qlu_decode
	import qlu_pkg::*;
(
	input  dec_state_t  cur,
	input  src_item_t   item,
	input  logic [7:0]  quote_char,
	input  logic [15:0] capacity,
	output dec_state_t  nxt,
	output logic        has_result,
	output res_item_t   result
);

	localparam dec_state_t IDLE = '{phase: PH_PLAIN, high_nibble: 4'd0, byte_count: 16'd0};

	logic [7:0]  c;
	logic [7:0]  folded;
	logic [4:0]  hv;
	logic        ended;
	logic        do_emit;
	logic [7:0]  emit_byte;
	logic [15:0] count_inc;

	assign c         = item.in_byte;
	assign ended     = item.at_end || (c == CH_NUL);
	assign folded    = fold_byte(c);
	assign hv        = hex_value(folded);
	assign count_inc = cur.byte_count + 16'd1;

	always_comb begin
		nxt        = cur;
		has_result = 1'b0;
		do_emit    = 1'b0;
		emit_byte  = c;
		result     = '{kind: KIND_ERROR, out_byte: 8'd0, error_code: ERR_NONE,
			decoded_length: cur.byte_count};
		if (ended) begin
			nxt        = IDLE;
			has_result = 1'b1;
			case (cur.phase)
				PH_PLAIN: begin
					result.out_byte   = quote_char;
					result.error_code = ERR_UNMATCHED;
				end
				PH_ESC: result.error_code = ERR_CUT_ESC;
				default: result.error_code = ERR_CUT_HEX;
			endcase
		end else begin
			case (cur.phase)
				PH_PLAIN: begin
					if (c == quote_char) begin
						nxt         = IDLE;
						has_result  = 1'b1;
						result.kind = KIND_CLOSE;
					end else if (c == CH_BACKSLASH) begin
						nxt.phase = PH_ESC;
					end else begin
						do_emit = 1'b1;
					end
				end
				PH_ESC: begin
					case (c) inside
						CH_SQUOTE, CH_DQUOTE, CH_BACKSLASH: do_emit = 1'b1;
						CH_LOWER_X: nxt.phase = PH_HEX1;
						CH_LOWER_T: begin
							do_emit   = 1'b1;
							emit_byte = CH_TAB;
						end
						CH_LOWER_N: begin
							do_emit   = 1'b1;
							emit_byte = CH_LF;
						end
						CH_LOWER_V: begin
							do_emit   = 1'b1;
							emit_byte = CH_VT;
						end
						CH_LOWER_F: begin
							do_emit   = 1'b1;
							emit_byte = CH_FF;
						end
						CH_LOWER_R: begin
							do_emit   = 1'b1;
							emit_byte = CH_CR;
						end
						default: begin
							nxt               = IDLE;
							has_result        = 1'b1;
							result.out_byte   = c;
							result.error_code = ERR_UNKNOWN;
						end
					endcase
				end
				PH_HEX1: begin
					if (hv[4]) begin
						nxt               = IDLE;
						has_result        = 1'b1;
						result.out_byte   = folded;
						result.error_code = ERR_BAD_HEX;
					end else begin
						nxt.high_nibble = hv[3:0];
						nxt.phase       = PH_HEX2;
					end
				end
				default: begin
					if (hv[4]) begin
						nxt               = IDLE;
						has_result        = 1'b1;
						result.out_byte   = folded;
						result.error_code = ERR_BAD_HEX;
					end else begin
						do_emit         = 1'b1;
						emit_byte       = {cur.high_nibble, hv[3:0]};
						nxt.high_nibble = 4'd0;
					end
				end
			endcase
		end
		if (do_emit) begin
			has_result            = 1'b1;
			result.out_byte       = emit_byte;
			result.decoded_length = count_inc;
			nxt.phase             = PH_PLAIN;
			nxt.byte_count        = count_inc;
			if (count_inc >= capacity) begin
				nxt               = IDLE;
				result.kind       = KIND_ERROR;
				result.error_code = ERR_FULL;
			end else begin
				result.kind = KIND_BYTE;
			end
		end
	end

endmodule
